/* rtl/atcpg_pkg.sv */
`timescale 1ns / 1ps

package atcpg_pkg;

    // Fixed part of the command frame: "AT+CONF="
    localparam int HEADER_LEN = 8;

    localparam logic [7:0] CHAR_A     = 8'h41;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] DIGIT_BASE = 8'd48;
    localparam logic [7:0] DIGIT_MAX  = 8'd9;

    localparam logic [7:0] HEADER_TEXT [HEADER_LEN] = '{
        8'h41, 8'h54, 8'h2B, 8'h43, 8'h4F, 8'h4E, 8'h46, 8'h3D
    };

    // Position of a character inside one channel group "dhl+"
    localparam logic [1:0] SLOT_DELAY = 2'd0;
    localparam logic [1:0] SLOT_HIGH  = 2'd1;
    localparam logic [1:0] SLOT_LOW   = 2'd2;
    localparam logic [1:0] SLOT_SEP   = 2'd3;

    // Per-channel control from the frame/tick logic
    typedef struct packed {
        logic       tick;
        logic       load;
        logic [3:0] delay_val;
        logic [3:0] high_val;
        logic [3:0] low_val;
    } chan_ctrl_t;

endpackage

/* rtl/atcpg_channel.sv */
`timescale 1ns / 1ps

module atcpg_channel
    import atcpg_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  chan_ctrl_t ctrl,
    output logic       lamp_next
);

    logic [3:0] delay_max_reg, high_max_reg, low_max_reg;
    logic [3:0] delay_left_reg, high_left_reg, low_left_reg;
    logic       lamp_reg;

    logic [3:0] delay_max_next, high_max_next, low_max_next;
    logic [3:0] delay_left_next, high_left_next, low_left_next;

    // Load new timing, or step the delay / high / low countdown on a tick
    always_comb
    begin
        delay_max_next  = delay_max_reg;
        high_max_next   = high_max_reg;
        low_max_next    = low_max_reg;
        delay_left_next = delay_left_reg;
        high_left_next  = high_left_reg;
        low_left_next   = low_left_reg;
        lamp_next       = lamp_reg;
        if (ctrl.load)
        begin
            delay_max_next  = ctrl.delay_val;
            high_max_next   = ctrl.high_val;
            low_max_next    = ctrl.low_val;
            delay_left_next = ctrl.delay_val;
            high_left_next  = ctrl.high_val;
            low_left_next   = ctrl.low_val;
            lamp_next       = 1'b0;
        end
        else if (ctrl.tick)
        begin
            priority if (delay_left_reg != 4'd0)
            begin
                delay_left_next = delay_left_reg - 4'd1;
                lamp_next       = 1'b0;
            end
            else if (high_left_reg != 4'd0)
            begin
                high_left_next = high_left_reg - 4'd1;
                lamp_next      = 1'b1;
            end
            else if (low_left_reg != 4'd0)
            begin
                low_left_next = low_left_reg - 4'd1;
                lamp_next     = 1'b0;
            end
            else
            begin
                // Period done: reload, keep the lamp as it is
                delay_left_next = delay_max_reg;
                high_left_next  = high_max_reg;
                low_left_next   = low_max_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_max_reg  <= 4'd0;
            high_max_reg   <= 4'd0;
            low_max_reg    <= 4'd0;
            delay_left_reg <= 4'd0;
            high_left_reg  <= 4'd0;
            low_left_reg   <= 4'd0;
            lamp_reg       <= 1'b0;
        end
        else
        begin
            delay_max_reg  <= delay_max_next;
            high_max_reg   <= high_max_next;
            low_max_reg    <= low_max_next;
            delay_left_reg <= delay_left_next;
            high_left_reg  <= high_left_next;
            low_left_reg   <= low_left_next;
            lamp_reg       <= lamp_next;
        end
    end

endmodule

/* rtl/at_command_three_channel_pulse_generator_core.sv */
`timescale 1ns / 1ps
// Path from input transaction to result: input register, then result register.
// One transaction per cycle unless stalled; frame and channel logic sit in one stage.
// in_stall rises only when both registers are full and out_stall holds the result.
// Reset (rst_n, async, active low): frame position, timings, counters and lamps clear.
// No clearing pass; the block takes transactions right after reset.

module at_command_three_channel_pulse_generator_core
    import atcpg_pkg::*;
#(
    parameter int CHANNELS = 3
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       kind,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       echo_valid,
    output logic [7:0] echo_byte,
    output logic       frame_accepted,
    output logic       frame_error,
    output logic [2:0] led_on
);

    localparam int FRAME_LEN = HEADER_LEN + 4 * CHANNELS - 1;
    localparam int PosW      = $clog2(FRAME_LEN);

    // Input register
    logic       in_valid_reg;
    logic       kind_reg;
    logic [7:0] byte_reg;

    // Frame tracking
    logic [PosW-1:0] pos_reg, pos_next, pos_eff, offset;
    logic            ok_reg, ok_next;
    logic [3:0]      pend_d_reg [CHANNELS];
    logic [3:0]      pend_h_reg [CHANNELS];
    logic [3:0]      pend_l_reg [CHANNELS];
    logic [3:0]      pend_d_next [CHANNELS];
    logic [3:0]      pend_h_next [CHANNELS];
    logic [3:0]      pend_l_next [CHANNELS];

    // Result register
    logic       out_valid_reg;
    logic       echo_valid_reg;
    logic [7:0] echo_byte_reg;
    logic       accepted_reg;
    logic       error_reg;
    logic [2:0] led_reg;

    logic       advance;
    logic       is_byte;
    logic       in_header;
    logic       char_ok;
    logic       frame_done;
    logic       good_frame;
    logic       bad_frame;
    logic [7:0] digit;
    logic [2:0] led_next;

    chan_ctrl_t chan_ctrl [CHANNELS];
    logic       lamp_next [CHANNELS];

    // Move the held transaction on whenever the result register frees up
    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && out_valid_reg && out_stall;

    assign is_byte = !kind_reg && (byte_reg != 8'd0);

    // Check each character against its place in the frame as it arrives
    always_comb
    begin
        pos_eff    = (byte_reg == CHAR_A) ? '0 : pos_reg;
        offset     = pos_eff - PosW'(HEADER_LEN);
        in_header  = pos_eff < PosW'(HEADER_LEN);
        digit      = byte_reg - DIGIT_BASE;
        frame_done = pos_eff == PosW'(FRAME_LEN - 1);
        if (in_header)
            char_ok = byte_reg == HEADER_TEXT[pos_eff[2:0]];
        else if (offset[1:0] == SLOT_SEP)
            char_ok = byte_reg == CHAR_PLUS;
        else
            char_ok = digit <= DIGIT_MAX;
        ok_next    = char_ok && ((pos_eff == '0) || ok_reg);
        good_frame = frame_done && ok_next;
        bad_frame  = frame_done && !ok_next;
        pos_next   = frame_done ? '0 : pos_eff + PosW'(1);
    end

    // Collect digits into the pending timing of the addressed channel
    always_comb
    begin
        for (int c = 0; c < CHANNELS; c++)
        begin
            pend_d_next[c] = pend_d_reg[c];
            pend_h_next[c] = pend_h_reg[c];
            pend_l_next[c] = pend_l_reg[c];
            if (!in_header && (offset[PosW-1:2] == (PosW-2)'(c)))
            begin
                unique case (offset[1:0])
                    SLOT_DELAY: pend_d_next[c] = digit[3:0];
                    SLOT_HIGH:  pend_h_next[c] = digit[3:0];
                    SLOT_LOW:   pend_l_next[c] = digit[3:0];
                    SLOT_SEP:   pend_l_next[c] = pend_l_reg[c];
                endcase
            end
        end
    end

    // Drive the channels
    always_comb
    begin
        for (int c = 0; c < CHANNELS; c++)
        begin
            chan_ctrl[c].tick      = advance && kind_reg;
            chan_ctrl[c].load      = advance && is_byte && good_frame;
            chan_ctrl[c].delay_val = pend_d_next[c];
            chan_ctrl[c].high_val  = pend_h_next[c];
            chan_ctrl[c].low_val   = pend_l_next[c];
        end
    end

    for (genvar g = 0; g < CHANNELS; g++)
    begin : g_chan
        atcpg_channel u_channel
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (chan_ctrl[g]),
            .lamp_next (lamp_next[g])
        );
    end

    // Report only the first three lamps
    always_comb
    begin
        led_next = 3'b000;
        for (int c = 0; c < 3; c++)
        begin
            if (c < CHANNELS)
                led_next[c] = lamp_next[c];
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (!in_stall)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            kind_reg <= kind;
            byte_reg <= rx_byte;
        end
    end

    // Frame position and running check
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            ok_reg  <= 1'b0;
        end
        else if (advance && is_byte)
        begin
            pos_reg <= pos_next;
            ok_reg  <= ok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && is_byte)
        begin
            pend_d_reg <= pend_d_next;
            pend_h_reg <= pend_h_next;
            pend_l_reg <= pend_l_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            echo_valid_reg <= is_byte;
            echo_byte_reg  <= is_byte ? byte_reg : 8'd0;
            accepted_reg   <= is_byte && good_frame;
            error_reg      <= is_byte && bad_frame;
            led_reg        <= led_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign echo_valid     = echo_valid_reg;
    assign echo_byte      = echo_byte_reg;
    assign frame_accepted = accepted_reg;
    assign frame_error    = error_reg;
    assign led_on         = led_reg;

endmodule

/* rtl/atcpg_checker.sv */
`timescale 1ns / 1ps

module atcpg_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic       echo_valid,
    input logic [7:0] echo_byte,
    input logic       frame_accepted,
    input logic       frame_error,
    input logic [2:0] led_on
);

    // Hold a stalled result transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(echo_byte) && $stable(led_on)
            && $stable(frame_accepted) && $stable(frame_error))
        else $error("stalled result changed");

    // A frame verdict comes only with an echoed byte, never both verdicts
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (frame_accepted || frame_error) |->
            echo_valid && !(frame_accepted && frame_error))
        else $error("frame verdict without echo or both set");

    // Without an echo the byte stays clear
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !echo_valid |-> echo_byte == 8'd0)
        else $error("echo byte set without echo");

    // An echoed byte is never zero
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && echo_valid |-> echo_byte != 8'd0)
        else $error("zero byte echoed");

    // A loaded frame turns every LED off
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_accepted |-> led_on == 3'b000)
        else $error("LED lit after frame load");

endmodule

bind at_command_three_channel_pulse_generator_core atcpg_checker u_atcpg_checker
(
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .echo_valid     (echo_valid),
    .echo_byte      (echo_byte),
    .frame_accepted (frame_accepted),
    .frame_error    (frame_error),
    .led_on         (led_on)
);

/* tb/sv/tb.sv */
`timescale 1ns / 1ps

module tb;
    import atcpg_pkg::*;

    localparam int CHANNELS       = 3;
    localparam int FRAME_LEN      = HEADER_LEN + 4 * CHANNELS - 1;
    localparam int DIRECTED_ROWS  = 26;
    localparam int RANDOM_ITEMS   = 2000;
    localparam int IDLE_PERCENT   = 19;
    localparam int CALM_START     = 800;
    localparam int CALM_END       = 1400;
    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 500;

    typedef enum logic {
        KIND_BYTE = 1'b0,
        KIND_TICK = 1'b1
    } item_kind_e;

    typedef struct packed {
        logic       echo_valid;
        logic [7:0] echo_byte;
        logic       frame_accepted;
        logic       frame_error;
        logic [2:0] led_on;
    } pulse_result_t;

    typedef struct packed {
        item_kind_e    kind;
        logic [7:0]    rx_byte;
        logic          has_exp;
        pulse_result_t exp;
    } stim_item_t;

    localparam pulse_result_t ZERO_RESULT = '0;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic       kind;
    logic [7:0] rx_byte;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic       echo_valid;
    logic [7:0] echo_byte;
    logic       frame_accepted;
    logic       frame_error;
    logic [2:0] led_on;

    // Directed part: extremes, no-data byte, frame restart, a good frame, ticks
    stim_item_t directed_rows [DIRECTED_ROWS] = '{
        '{KIND_TICK, 8'h00, 1'b1, ZERO_RESULT},
        '{KIND_BYTE, 8'h00, 1'b1, ZERO_RESULT},
        '{KIND_BYTE, 8'hFF, 1'b1, '{1'b1, 8'hFF, 1'b0, 1'b0, 3'b000}},
        '{KIND_BYTE, 8'h01, 1'b1, '{1'b1, 8'h01, 1'b0, 1'b0, 3'b000}},
        '{KIND_BYTE, "A", 1'b0, ZERO_RESULT},
        '{KIND_BYTE, "T", 1'b0, ZERO_RESULT},
        '{KIND_BYTE, "+", 1'b0, ZERO_RESULT},
        '{KIND_BYTE, "C", 1'b0, ZERO_RESULT},
        '{KIND_BYTE, "O", 1'b0, ZERO_RESULT},
        '{KIND_BYTE, "N", 1'b0, ZERO_RESULT},
        '{KIND_BYTE, "F", 1'b0, ZERO_RESULT},
        '{KIND_BYTE, "=", 1'b0, ZERO_RESULT},
        '{KIND_BYTE, "0", 1'b0, ZERO_RESULT},
        '{KIND_BYTE, "9", 1'b0, ZERO_RESULT},
        '{KIND_BYTE, "0", 1'b0, ZERO_RESULT},
        '{KIND_BYTE, "+", 1'b0, ZERO_RESULT},
        '{KIND_BYTE, "9", 1'b0, ZERO_RESULT},
        '{KIND_BYTE, "0", 1'b0, ZERO_RESULT},
        '{KIND_BYTE, "9", 1'b0, ZERO_RESULT},
        '{KIND_BYTE, "+", 1'b0, ZERO_RESULT},
        '{KIND_BYTE, "0", 1'b0, ZERO_RESULT},
        '{KIND_BYTE, "0", 1'b0, ZERO_RESULT},
        '{KIND_BYTE, "0", 1'b1, '{1'b1, "0", 1'b1, 1'b0, 3'b000}},
        '{KIND_TICK, 8'h00, 1'b0, ZERO_RESULT},
        '{KIND_TICK, 8'hFF, 1'b0, ZERO_RESULT},
        '{KIND_TICK, 8'hA5, 1'b0, ZERO_RESULT}
    };

    stim_item_t    stim_q[$];
    stim_item_t    cur_row;
    pulse_result_t expected_q[$];

    // Predictor state
    logic [7:0]  frame_mem [FRAME_LEN];
    int unsigned frame_pos = 0;
    logic [3:0]  delay_top [CHANNELS] = '{default: '0};
    logic [3:0]  high_top  [CHANNELS] = '{default: '0};
    logic [3:0]  low_top   [CHANNELS] = '{default: '0};
    logic [3:0]  delay_cnt [CHANNELS] = '{default: '0};
    logic [3:0]  high_cnt  [CHANNELS] = '{default: '0};
    logic [3:0]  low_cnt   [CHANNELS] = '{default: '0};
    logic        lamp      [CHANNELS] = '{default: 1'b0};

    int unsigned good_frames  = 0;
    int unsigned bad_frames   = 0;
    int unsigned tick_count   = 0;
    int unsigned items_in     = 0;
    int unsigned results_seen = 0;
    int unsigned fail_cnt     = 0;
    int unsigned cycle_cnt    = 0;
    int unsigned quiet_cycles = 0;
    bit          in_fired     = 1'b0;
    logic        calm;

    at_command_three_channel_pulse_generator_core #(
        .CHANNELS(CHANNELS)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .kind          (kind),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .echo_valid    (echo_valid),
        .echo_byte     (echo_byte),
        .frame_accepted(frame_accepted),
        .frame_error   (frame_error),
        .led_on        (led_on)
    );

    always #1 clk = ~clk;

    assign calm = (cycle_cnt >= CALM_START) && (cycle_cnt < CALM_END);

    // Digit value of one frame character, wrapping below the digit base
    function automatic logic [7:0] frame_digit(int idx);
        return frame_mem[idx] - DIGIT_BASE;
    endfunction

    function automatic bit frame_is_good();
        for (int i = 0; i < HEADER_LEN; i++)
            if (frame_mem[i] != HEADER_TEXT[i])
                return 1'b0;
        for (int c = 0; c < CHANNELS; c++)
        begin
            if (c > 0 && frame_mem[HEADER_LEN + 4 * c - 1] != CHAR_PLUS)
                return 1'b0;
            for (int i = 0; i < 3; i++)
                if (frame_digit(HEADER_LEN + 4 * c + i) > DIGIT_MAX)
                    return 1'b0;
        end
        return 1'b1;
    endfunction

    // Advance the pulse generator by one transaction and return its result
    function automatic pulse_result_t step_pulse_model(item_kind_e k, logic [7:0] b);
        pulse_result_t r;
        int            base;
        r = '0;
        if (k == KIND_TICK)
        begin
            tick_count++;
            for (int c = 0; c < CHANNELS; c++)
            begin
                if (delay_cnt[c] != 0)
                begin
                    delay_cnt[c]--;
                    lamp[c] = 1'b0;
                end
                else if (high_cnt[c] != 0)
                begin
                    high_cnt[c]--;
                    lamp[c] = 1'b1;
                end
                else if (low_cnt[c] != 0)
                begin
                    low_cnt[c]--;
                    lamp[c] = 1'b0;
                end
                else
                begin
                    delay_cnt[c] = delay_top[c];
                    high_cnt[c]  = high_top[c];
                    low_cnt[c]   = low_top[c];
                end
            end
        end
        else if (b != 8'h00)
        begin
            r.echo_valid = 1'b1;
            r.echo_byte  = b;
            if (b == CHAR_A)
                frame_pos = 0;
            if (frame_pos >= FRAME_LEN)
                frame_pos = 0;
            frame_mem[frame_pos] = b;
            frame_pos++;
            if (frame_pos == FRAME_LEN)
            begin
                if (frame_is_good())
                begin
                    for (int c = 0; c < CHANNELS; c++)
                    begin
                        base         = HEADER_LEN + 4 * c;
                        delay_top[c] = 4'(frame_digit(base));
                        high_top[c]  = 4'(frame_digit(base + 1));
                        low_top[c]   = 4'(frame_digit(base + 2));
                        delay_cnt[c] = delay_top[c];
                        high_cnt[c]  = high_top[c];
                        low_cnt[c]   = low_top[c];
                        lamp[c]      = 1'b0;
                    end
                    r.frame_accepted = 1'b1;
                    good_frames++;
                end
                else
                begin
                    r.frame_error = 1'b1;
                    bad_frames++;
                end
                frame_pos = 0;
            end
        end
        for (int c = 0; c < CHANNELS && c < 3; c++)
            r.led_on[c] = lamp[c];
        return r;
    endfunction

    function automatic void push_item(item_kind_e k, logic [7:0] b);
        stim_item_t s;
        s         = '0;
        s.kind    = k;
        s.rx_byte = b;
        stim_q.push_back(s);
    endfunction

    // Queue one command frame with random digits, ticks sprinkled in; optionally spoil one byte
    task automatic push_frame(bit spoil);
        logic [7:0] text [FRAME_LEN];
        int         base;
        int         bad_pos;
        for (int i = 0; i < HEADER_LEN; i++)
            text[i] = HEADER_TEXT[i];
        for (int c = 0; c < CHANNELS; c++)
        begin
            base = HEADER_LEN + 4 * c;
            if (c > 0)
                text[base - 1] = CHAR_PLUS;
            for (int i = 0; i < 3; i++)
                text[base + i] = DIGIT_BASE + 8'($urandom_range(DIGIT_MAX));
        end
        if (spoil)
        begin
            bad_pos = $urandom_range(FRAME_LEN - 1);
            case ($urandom_range(2))
                0:       text[bad_pos] = DIGIT_BASE - 8'd1;
                1:       text[bad_pos] = DIGIT_BASE + DIGIT_MAX + 8'd1;
                default: text[bad_pos] = 8'($urandom_range(255, 1));
            endcase
        end
        for (int i = 0; i < FRAME_LEN; i++)
        begin
            if ($urandom_range(9) == 0)
                push_item(KIND_TICK, 8'($urandom_range(255)));
            push_item(KIND_BYTE, text[i]);
        end
    endtask

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] seen);
        if (want !== seen)
        begin
            $error("%s: expected %0d, got %0d", name, want, seen);
            fail_cnt++;
        end
    endfunction

    // Stimulus and final report
    initial
    begin
        int unsigned idx;
        int unsigned n;
        int unsigned sel;
        rst_n    = 1'b0;
        in_valid = 1'b0;
        kind     = KIND_BYTE;
        rx_byte  = 8'h00;
        cur_row  = '0;

        for (int i = 0; i < DIRECTED_ROWS; i++)
            stim_q.push_back(directed_rows[i]);

        // Mostly whole frames and tick bursts; the rest broken frames and raw noise
        while (stim_q.size() < DIRECTED_ROWS + RANDOM_ITEMS)
        begin
            sel = $urandom_range(99);
            if (sel < 40)
                push_frame(1'b0);
            else if (sel < 55)
                push_frame(1'b1);
            else if (sel < 85)
            begin
                n = $urandom_range(40, 1);
                repeat (n) push_item(KIND_TICK, 8'($urandom_range(255)));
            end
            else
            begin
                n = $urandom_range(8, 1);
                repeat (n)
                    push_item(KIND_BYTE,
                              ($urandom_range(3) == 0) ? 8'd0 : 8'($urandom_range(255)));
            end
        end

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Present transactions; hold a stalled one, idle at random otherwise
        idx = 0;
        while (idx < stim_q.size())
        begin
            @(negedge clk);
            if (in_valid && in_fired)
                idx++;
            if (!(in_valid && !in_fired))
            begin
                if (idx < stim_q.size() && (calm || $urandom_range(99) >= IDLE_PERCENT))
                begin
                    cur_row  = stim_q[idx];
                    kind     = cur_row.kind;
                    rx_byte  = cur_row.rx_byte;
                    in_valid = 1'b1;
                end
                else
                    in_valid = 1'b0;
            end
        end

        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d transactions (%0d ticks), %0d results checked.",
                 items_in, tick_count, results_seen);
        $display("Frames loaded: %0d, frames rejected: %0d.", good_frames, bad_frames);
        if (fail_cnt == 0 && expected_q.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Randomly stall the result side outside the calm window
    always @(negedge clk)
    begin
        out_stall = calm ? 1'b0 : ($urandom_range(99) < IDLE_PERCENT);
    end

    // Predict on each accepted transaction, compare each accepted result
    always @(posedge clk)
    begin
        pulse_result_t predicted;
        in_fired = 1'b0;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                in_fired = 1'b1;
                items_in++;
                predicted = step_pulse_model(item_kind_e'(kind), rx_byte);
                if (cur_row.has_exp)
                    predicted = cur_row.exp;
                expected_q.push_back(predicted);
            end
            if (out_valid && !out_stall)
            begin
                if (expected_q.size() == 0)
                begin
                    $error("result transaction with no expectation pending");
                    fail_cnt++;
                end
                else
                begin
                    predicted = expected_q.pop_front();
                    results_seen++;
                    check_field("echo_valid", 8'(predicted.echo_valid), 8'(echo_valid));
                    check_field("echo_byte", predicted.echo_byte, echo_byte);
                    check_field("frame_accepted", 8'(predicted.frame_accepted),
                                8'(frame_accepted));
                    check_field("frame_error", 8'(predicted.frame_error), 8'(frame_error));
                    check_field("led_on", 8'(predicted.led_on), 8'(led_on));
                end
            end
        end
    end

    // Stop the run when no transaction moves for too long
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

endmodule
